// ===== rtl/cprr_pkg.sv =====
`default_nettype none
package cprr_pkg;

	localparam int CORDIC_W   = 34;
	localparam int ANGLE_W    = 32;
	localparam int FRAC_BITS  = 30;
	localparam int DIV_BITS   = 4;
	localparam int RAMP_SHIFT = 22;

	localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;

	// atan(2^-k) in units of 2^-32 turn
	localparam logic [ANGLE_W-1:0] ATAN_TURNS [32] = '{
		32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20860,
		32'd10430,     32'd5215,      32'd2607,      32'd1303,
		32'd651,       32'd325,       32'd162,       32'd81,
		32'd40,        32'd20,        32'd10,        32'd5,
		32'd2,         32'd1,         32'd0,         32'd0
	};

	typedef struct packed {
		logic signed [CORDIC_W-1:0] cos_v;
		logic signed [CORDIC_W-1:0] sin_v;
	} trig_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] quo;
		logic               rem_nz;
	} div_res_t;

endpackage
`default_nettype wire

// ===== rtl/cprr_div.sv =====
`default_nettype none
// radix-16 restoring divider, keeps the low 32 quotient bits
module cprr_div #(
	parameter int DW = 48,
	parameter int NW = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DW-1:0]      dividend,
	input  wire logic [NW-1:0]      divisor,
	output logic                    done,
	output cprr_pkg::div_res_t      res
);

	localparam int ITER = DW / cprr_pkg::DIV_BITS;
	localparam int CNW  = $clog2(ITER + 1);

	logic [DW-1:0]                    dvd_q;
	logic [NW-1:0]                    dsr_q;
	logic [NW-1:0]                    rem_q;
	logic [cprr_pkg::ANGLE_W-1:0]     quo_q;
	logic [CNW-1:0]                   cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [NW:0]                      r;
	logic [cprr_pkg::DIV_BITS-1:0]    qb;

	always_comb begin
		r  = {1'b0, rem_q};
		qb = '0;
		for (int j = 0; j < cprr_pkg::DIV_BITS; j++) begin
			r = {r[NW-1:0], dvd_q[DW-1-j]};
			if (r >= {1'b0, dsr_q}) begin
				r = r - {1'b0, dsr_q};
				qb[cprr_pkg::DIV_BITS-1-j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(ITER - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << cprr_pkg::DIV_BITS;
			rem_q <= r[NW-1:0];
			quo_q <= {quo_q[cprr_pkg::ANGLE_W-1-cprr_pkg::DIV_BITS:0], qb};
		end
	end

	assign done       = done_q;
	assign res.quo    = quo_q;
	assign res.rem_nz = |rem_q;

endmodule
`default_nettype wire

// ===== rtl/cprr_cordic.sv =====
`default_nettype none
// rotation-mode CORDIC, one micro-rotation per cycle
module cprr_cordic #(
	parameter int STAGES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [cprr_pkg::ANGLE_W-1:0]  angle,
	output logic                               done,
	output cprr_pkg::trig_t                    trig
);

	localparam int CW = cprr_pkg::CORDIC_W;
	localparam int KW = $clog2(STAGES);

	logic [KW-1:0]                  k_q;
	logic                           busy_q;
	logic                           fin_q;
	logic                           done_q;
	logic                           flip_q;
	logic signed [CW-1:0]           x_q, y_q, z_q;
	logic signed [CW-1:0]           x_sh, y_sh, x_nx, y_nx, z_nx, atan_v;
	logic [cprr_pkg::ANGLE_W-1:0]   turn_a, ang_r;
	logic                           flip;
	cprr_pkg::trig_t                trig_q;

	// fold [1/4, 3/4) turn onto the right half plane
	assign turn_a = angle + 32'h4000_0000;
	assign flip   = turn_a[cprr_pkg::ANGLE_W-1];
	assign ang_r  = {angle[cprr_pkg::ANGLE_W-1] ^ flip, angle[cprr_pkg::ANGLE_W-2:0]};

	assign atan_v = $signed({2'b00, cprr_pkg::ATAN_TURNS[5'(k_q)]});
	assign x_sh   = x_q >>> k_q;
	assign y_sh   = y_q >>> k_q;

	always_comb begin
		if (!z_q[CW-1]) begin
			x_nx = x_q - y_sh;
			y_nx = y_q + x_sh;
			z_nx = z_q - atan_v;
		end else begin
			x_nx = x_q + y_sh;
			y_nx = y_q - x_sh;
			z_nx = z_q + atan_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == KW'(STAGES - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= cprr_pkg::CORDIC_INV_GAIN;
			y_q    <= '0;
			z_q    <= $signed({{(CW-cprr_pkg::ANGLE_W){ang_r[cprr_pkg::ANGLE_W-1]}}, ang_r});
			flip_q <= flip;
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
		if (fin_q) begin
			trig_q.cos_v <= flip_q ? -x_q : x_q;
			trig_q.sin_v <= flip_q ? -y_q : y_q;
		end
	end

	assign done = done_q;
	assign trig = trig_q;

endmodule
`default_nettype wire

// ===== rtl/cprr_cmul.sv =====
`default_nettype none
// complex multiply on one shared multiplier, round and saturate
module cprr_cmul #(
	parameter int SW = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire cprr_pkg::trig_t      trig,
	input  wire logic signed [SW-1:0] sr,
	input  wire logic signed [SW-1:0] si,
	output logic                      done,
	output logic signed [SW-1:0]      re,
	output logic signed [SW-1:0]      im
);

	localparam int CW = cprr_pkg::CORDIC_W;
	localparam int PW = CW + SW;
	localparam int AW = PW + 2;
	localparam int TW = AW - cprr_pkg::FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_M0   = 3'd1;
	localparam logic [2:0] ST_M1   = 3'd2;
	localparam logic [2:0] ST_M2   = 3'd3;
	localparam logic [2:0] ST_M3   = 3'd4;
	localparam logic [2:0] ST_M4   = 3'd5;

	localparam logic signed [AW-1:0] RND =
		{{(AW-cprr_pkg::FRAC_BITS){1'b0}}, 1'b1, {(cprr_pkg::FRAC_BITS-1){1'b0}}};

	logic [2:0]              st_q;
	logic                    done_q;
	logic signed [CW-1:0]    c_q, s_q, op_a;
	logic signed [SW-1:0]    sr_q, si_q, op_b;
	logic signed [PW-1:0]    prod_q, prod_nx;
	logic signed [AW-1:0]    acc_q, sum_sub, sum_add;
	logic signed [SW-1:0]    re_q, im_q;

	function automatic logic signed [SW-1:0] sat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] sh;
		logic signed [TW-1:0] t;
		sh = v >>> cprr_pkg::FRAC_BITS;
		t  = sh[TW-1:0];
		if ((&t[TW-1:SW-1]) || (~|t[TW-1:SW-1]))
			sat = t[SW-1:0];
		else if (t[TW-1])
			sat = {1'b1, {(SW-1){1'b0}}};
		else
			sat = {1'b0, {(SW-1){1'b1}}};
	endfunction

	assign op_a    = (st_q == ST_M0 || st_q == ST_M3) ? c_q : s_q;
	assign op_b    = (st_q == ST_M0 || st_q == ST_M2) ? sr_q : si_q;
	assign prod_nx = PW'(op_a) * PW'(op_b);
	assign sum_sub = acc_q - AW'(prod_q);
	assign sum_add = acc_q + AW'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (start) st_q <= ST_M0;
				ST_M0:   st_q <= ST_M1;
				ST_M1:   st_q <= ST_M2;
				ST_M2:   st_q <= ST_M3;
				ST_M3:   st_q <= ST_M4;
				ST_M4: begin
					st_q   <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && st_q == ST_IDLE) begin
			c_q  <= trig.cos_v;
			s_q  <= trig.sin_v;
			sr_q <= sr;
			si_q <= si;
		end
		prod_q <= prod_nx;
		if (st_q == ST_M1 || st_q == ST_M3)
			acc_q <= AW'(prod_q) + RND;
		if (st_q == ST_M2)
			re_q <= sat(sum_sub);
		if (st_q == ST_M4)
			im_q <= sat(sum_add);
	end

	assign done = done_q;
	assign re   = re_q;
	assign im   = im_q;

endmodule
`default_nettype wire

// ===== rtl/complex_phase_ramp_rotator.sv =====
`default_nettype none
// Complex phase-ramp rotator.
// Input words on s_tvalid/s_tready/s_tdata carry one complex Q1.15 sample each;
// the block numbers them 0..n-1 itself and rotates sample i by
// +-(i*ramp_scale/(1024n) + phase_offset/65536) turn. Output words on
// m_tvalid/m_tready/m_tdata carry the saturated result, m_tlast marks element n-1.
// Registers (APB, byte address 4*i): vector_length, rotate_negative, ramp_scale,
// phase_offset. Write them only while no word is in flight.
// One word at a time: an item passes from accept to m_tvalid through the
// 4-bit-per-cycle ramp divider, the one-stage-per-cycle CORDIC and the four
// passes through the single multiplier; s_tready rises together with
// m_tvalid and the next word can be taken at the following edge, so the
// block takes no new word before it is through with the last one.
// A result sits in the output register while the next word is accepted;
// if m_tready stays low the finished result waits in the multiplier unit and
// s_tready stays low until the output register frees.
// Reset clears the position counter and sets the registers to 1024, 0, 256, 0.
module complex_phase_ramp_rotator #(
	parameter int MAX_LENGTH    = 1024,
	parameter int SAMPLE_WIDTH  = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	// sample_re, sample_im
	input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	// rotated_re, rotated_im
	output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]          m_tdata,
	output logic                                         m_tlast,
	input  wire logic                                    psel,
	input  wire logic                                    penable,
	input  wire logic                                    pwrite,
	input  wire logic [3:0]                              paddr,
	input  wire logic [31:0]                             pwdata,
	output logic [31:0]                                  prdata,
	output logic                                         pready
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int TD_W   = ((2*SAMPLE_WIDTH+7)/8)*8;
	localparam int PW     = $clog2(MAX_LENGTH);
	localparam int NW     = $clog2(MAX_LENGTH + 1);
	localparam int MAG_W  = PW + 16;
	localparam int MW     = MAG_W + 1;
	localparam int DIV_W  = ((MAG_W + cprr_pkg::RAMP_SHIFT + cprr_pkg::DIV_BITS - 1)
		/ cprr_pkg::DIV_BITS) * cprr_pkg::DIV_BITS;
	localparam int AW     = cprr_pkg::ANGLE_W;

	localparam logic [1:0] REG_VECTOR_LENGTH   = 2'd0;
	localparam logic [1:0] REG_ROTATE_NEGATIVE = 2'd1;
	localparam logic [1:0] REG_RAMP_SCALE      = 2'd2;
	localparam logic [1:0] REG_PHASE_OFFSET    = 2'd3;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RAMP   = 3'd1;
	localparam logic [2:0] S_DSTART = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_ANG    = 3'd4;
	localparam logic [2:0] S_ROT    = 3'd5;
	localparam logic [2:0] S_MIX    = 3'd6;
	localparam logic [2:0] S_HOLD   = 3'd7;

	logic [10:0]               vector_length_q;
	logic                      rotate_negative_q;
	logic signed [15:0]        ramp_scale_q;
	logic [15:0]               phase_offset_q;
	logic [1:0]                reg_idx;
	logic                      cfg_wr;

	logic [2:0]                state_q;
	logic [PW-1:0]             pos_q, item_pos_q;
	logic                      item_last_q;
	logic signed [SW-1:0]      sr_q, si_q;
	logic signed [MW-1:0]      p_q, p_abs;
	logic [AW-1:0]             angle_q, q_mag, q_v, ang_sum, ang_nx;
	logic [31:0]               n_wide;
	logic [NW-1:0]             n_eff;
	logic                      last_in;
	logic                      s_acc;

	logic                      div_start, div_done;
	logic [DIV_W-1:0]          dividend;
	cprr_pkg::div_res_t        div_res;
	logic                      cor_start, cor_done;
	cprr_pkg::trig_t           trig;
	logic                      mix_start, mix_done;
	logic signed [SW-1:0]      mix_re, mix_im;

	logic                      m_tvalid_q;
	logic                      out_load;
	logic signed [SW-1:0]      out_re_q, out_im_q;
	logic                      out_last_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q   <= 11'd1024;
			rotate_negative_q <= 1'b0;
			ramp_scale_q      <= 16'sd256;
			phase_offset_q    <= 16'd0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_VECTOR_LENGTH:   vector_length_q   <= pwdata[10:0];
				REG_ROTATE_NEGATIVE: rotate_negative_q <= pwdata[0];
				REG_RAMP_SCALE:      ramp_scale_q      <= $signed(pwdata[15:0]);
				REG_PHASE_OFFSET:    phase_offset_q    <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_VECTOR_LENGTH:   prdata = {21'd0, vector_length_q};
			REG_ROTATE_NEGATIVE: prdata = {31'd0, rotate_negative_q};
			REG_RAMP_SCALE:      prdata = {16'd0, ramp_scale_q};
			REG_PHASE_OFFSET:    prdata = {16'd0, phase_offset_q};
		endcase
	end

	// effective vector length: zero acts as one, clamp at MAX_LENGTH
	assign n_wide = (vector_length_q == '0) ? 32'd1 :
		((32'(vector_length_q) > 32'(MAX_LENGTH)) ? 32'(MAX_LENGTH) : 32'(vector_length_q));
	assign n_eff   = n_wide[NW-1:0];
	assign last_in = (32'(pos_q) + 32'd1) >= n_wide;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid & s_tready;

	// ramp numerator magnitude, then floor correction for negative ramps
	assign p_abs     = p_q[MW-1] ? -p_q : p_q;
	assign dividend  = DIV_W'(p_abs[MAG_W-1:0]) << cprr_pkg::RAMP_SHIFT;
	assign q_mag     = div_res.quo + AW'(div_res.rem_nz);
	assign q_v       = p_q[MW-1] ? -q_mag : div_res.quo;
	assign ang_sum   = q_v + {phase_offset_q, 16'h0000};
	assign ang_nx    = rotate_negative_q ? -ang_sum : ang_sum;

	assign div_start = (state_q == S_DSTART);
	assign cor_start = (state_q == S_ANG);
	assign mix_start = (state_q == S_ROT) && cor_done;
	assign out_load  = ((state_q == S_MIX && mix_done) || state_q == S_HOLD) &&
		(!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
		end else begin
			if (s_acc)
				pos_q <= last_in ? '0 : pos_q + 1'b1;
			unique case (state_q)
				S_IDLE:   if (s_acc) state_q <= S_RAMP;
				S_RAMP:   state_q <= S_DSTART;
				S_DSTART: state_q <= S_DIV;
				S_DIV:    if (div_done) state_q <= S_ANG;
				S_ANG:    state_q <= S_ROT;
				S_ROT:    if (cor_done) state_q <= S_MIX;
				S_MIX: begin
					if (mix_done)
						state_q <= out_load ? S_IDLE : S_HOLD;
				end
				S_HOLD:   if (out_load) state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_pos_q  <= pos_q;
			item_last_q <= last_in;
			sr_q        <= $signed(s_tdata[SW-1:0]);
			si_q        <= $signed(s_tdata[2*SW-1:SW]);
		end
		if (state_q == S_RAMP)
			p_q <= MW'($signed({1'b0, item_pos_q})) * MW'(ramp_scale_q);
		if (state_q == S_DIV && div_done)
			angle_q <= ang_nx;
	end

	cprr_div #(
		.DW (DIV_W),
		.NW (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (n_eff),
		.done     (div_done),
		.res      (div_res)
	);

	cprr_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (angle_q),
		.done   (cor_done),
		.trig   (trig)
	);

	cprr_cmul #(
		.SW (SW)
	) u_cmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.trig   (trig),
		.sr     (sr_q),
		.si     (si_q),
		.done   (mix_done),
		.re     (mix_re),
		.im     (mix_im)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_re_q   <= mix_re;
			out_im_q   <= mix_im;
			out_last_q <= item_last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TD_W'({out_im_q, out_re_q});
	assign m_tlast  = out_last_q;

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && last_in |=> pos_q == '0)
		else $error("position did not wrap after last element");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_cor_done: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == S_ROT)
		else $error("cordic finished outside rotate state");

	a_mix_done: assert property (@(posedge clk) disable iff (!arst_n)
		mix_done |-> state_q == S_MIX)
		else $error("multiplier finished outside mix state");

endmodule
`default_nettype wire
